### hdl/wfr_pkg.sv
`timescale 1ns / 1ps

package wfr_pkg;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int SUM_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMPERATURE_CODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESSURE_CODE = 2'd1;

   localparam logic [7:0] TEMPERATURE_CODE_RESET = 8'd66;
   localparam logic [7:0] PRESSURE_CODE_RESET = 8'd70;

   localparam logic [3:0] SHORT_TRANSFER_MAX = 4'd1;
   localparam logic [7:0] COUNT_LIMIT = 8'd10;
   localparam logic [7:0] MARKER_COUNT = 8'h01;
   localparam logic [7:0] MARKER_BYTE = 8'hff;
   localparam logic [2:0] COPY_MAX = 3'd7;
   localparam logic [3:0] NIBBLE_MASK = 4'h0f;

   // floor(x / 10) = (x * 0xcccd) >> 19 for any x below 2**16
   localparam logic [15:0] DIV10_MUL = 16'hcccd;
   localparam int DIV10_SHIFT = 19;
   localparam int PROD_W = 28;

   localparam logic [1:0] KIND_TEMPERATURE = 2'd0;
   localparam logic [1:0] KIND_PRESSURE = 2'd1;
   localparam logic [1:0] KIND_OTHER = 2'd2;

   typedef struct packed {
      logic load;
      logic clear_frame;
      logic set_marker;
      logic copy_step;
      logic scan_step;
      logic emit;
   } wfr_cmd_type;

   typedef struct packed {
      logic short_item;
      logic big_count;
      logic is_marker;
      logic frame_empty;
      logic marker_set;
      logic frame_short;
      logic copy_done;
      logic scan_done;
      logic sum_ok;
      logic out_busy;
   } wfr_status_type;

endpackage

### hdl/wfr_ram.sv
`timescale 1ns / 1ps

module wfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/wfr_datapath.sv
`timescale 1ns / 1ps

module wfr_datapath #(
   parameter int FRAME_BYTES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [3:0]                           transfer_length,
   input  logic [7:0]                           count_byte,
   input  logic [7:0]                           payload [7],
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wfr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wfr_pkg::CSR_DATA_W-1:0]       csr_data,
   input  wfr_pkg::wfr_cmd_type                 cmd,
   output wfr_pkg::wfr_status_type              status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wfr_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int LEN_W = $clog2(FRAME_BYTES + 1);
   localparam int ADDR_W = $clog2(FRAME_BYTES);

   logic [7:0] temp_code_ff, pres_code_ff;
   logic [3:0] len_ff;
   logic [7:0] count_ff;
   logic [7:0] pay_ff [7];

   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic             marker_ff, marker_in;
   logic [2:0]       copy_idx_ff, copy_idx_in;
   logic [2:0]       copy_n;
   logic             wr_en;

   logic [LEN_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LEN_W-1:0] rd_pos_ff;
   logic             rd_vld_ff;
   logic             rd_issue;
   logic [7:0]       rd_data;
   logic [LEN_W-1:0] chk_pos;

   logic [wfr_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [wfr_pkg::SUM_W-1:0] chk_ff, chk_in;
   logic [7:0]                hdr_ff [5];
   logic [7:0]                hdr_in [5];

   logic [11:0]                 raw_temp;
   logic [wfr_pkg::PROD_W-1:0]  prod_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [wfr_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]                      kind;
   logic [3:0]                      sensor;
   logic [8:0]                      temp_value;
   logic [7:0]                      humidity;
   logic [11:0]                     pres_value, alt_value;
   logic [3:0]                      forecast, second_forecast;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_code_ff <= wfr_pkg::TEMPERATURE_CODE_RESET;
         pres_code_ff <= wfr_pkg::PRESSURE_CODE_RESET;
      end else if (csr_valid) begin
         if (csr_index == wfr_pkg::CSR_TEMPERATURE_CODE) begin
            temp_code_ff <= csr_data;
         end
         if (csr_index == wfr_pkg::CSR_PRESSURE_CODE) begin
            pres_code_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff <= transfer_length;
         count_ff <= count_byte;
         pay_ff <= payload;
      end
   end

   // append path
   assign copy_n = (count_ff > 8'(wfr_pkg::COPY_MAX)) ? wfr_pkg::COPY_MAX : count_ff[2:0];
   assign status.copy_done = (copy_idx_ff >= copy_n) ||
                             (frame_len_ff == LEN_W'(FRAME_BYTES));
   assign wr_en = cmd.copy_step && !status.copy_done;

   always_comb begin
      frame_len_in = frame_len_ff;
      marker_in = marker_ff;
      copy_idx_in = copy_idx_ff;
      if (cmd.load) begin
         copy_idx_in = 3'd0;
      end else if (wr_en) begin
         copy_idx_in = copy_idx_ff + 3'd1;
      end
      if (cmd.clear_frame) begin
         frame_len_in = '0;
         marker_in = 1'b0;
      end else begin
         if (wr_en) begin
            frame_len_in = frame_len_ff + LEN_W'(1);
         end
         if (cmd.set_marker) begin
            marker_in = 1'b1;
         end
      end
   end

   // checksum scan over the stored frame
   assign rd_issue = cmd.scan_step && (rd_ptr_ff != frame_len_ff);
   assign rd_ptr_in = cmd.load ? '0 : (rd_issue ? rd_ptr_ff + LEN_W'(1) : rd_ptr_ff);
   assign chk_pos = frame_len_ff - LEN_W'(2);

   always_comb begin
      sum_in = sum_ff;
      chk_in = chk_ff;
      hdr_in = hdr_ff;
      if (cmd.load) begin
         sum_in = '0;
         chk_in = '0;
         for (int k = 0; k < 5; k++) begin
            hdr_in[k] = 8'd0;
         end
      end else if (rd_vld_ff) begin
         if (rd_pos_ff < chk_pos) begin
            sum_in = sum_ff + wfr_pkg::SUM_W'(rd_data);
         end
         if (rd_pos_ff == chk_pos) begin
            chk_in[7:0] = rd_data;
         end
         if (rd_pos_ff == chk_pos + LEN_W'(1)) begin
            chk_in[15:8] = rd_data;
         end
         for (int k = 0; k < 5; k++) begin
            if (rd_pos_ff == LEN_W'(k + 1)) begin
               hdr_in[k] = rd_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= '0;
         marker_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_len_ff <= frame_len_in;
         marker_ff <= marker_in;
         rd_vld_ff <= rd_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_idx_ff <= copy_idx_in;
      rd_ptr_ff <= rd_ptr_in;
      rd_pos_ff <= rd_ptr_ff;
      sum_ff <= sum_in;
      chk_ff <= chk_in;
      hdr_ff <= hdr_in;
      prod_ff <= wfr_pkg::PROD_W'(raw_temp) * wfr_pkg::PROD_W'(wfr_pkg::DIV10_MUL);
      rsp_data_ff <= rsp_data_in;
   end

   wfr_ram #(
      .WIDTH(8),
      .DEPTH(FRAME_BYTES)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (frame_len_ff[ADDR_W-1:0]),
      .wr_data (pay_ff[copy_idx_ff]),
      .rd_en   (rd_issue),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // record decode
   assign raw_temp = {hdr_ff[3][3:0] & wfr_pkg::NIBBLE_MASK, hdr_ff[2]};

   always_comb begin
      kind = wfr_pkg::KIND_OTHER;
      sensor = 4'd0;
      temp_value = 9'd0;
      humidity = 8'd0;
      pres_value = 12'd0;
      forecast = 4'd0;
      alt_value = 12'd0;
      second_forecast = 4'd0;
      if (hdr_ff[0] == temp_code_ff) begin
         kind = wfr_pkg::KIND_TEMPERATURE;
         sensor = hdr_ff[1][3:0] & wfr_pkg::NIBBLE_MASK;
         temp_value = prod_ff[wfr_pkg::DIV10_SHIFT +: 9];
         humidity = hdr_ff[4];
      end else if (hdr_ff[0] == pres_code_ff) begin
         kind = wfr_pkg::KIND_PRESSURE;
         pres_value = {hdr_ff[2][3:0], hdr_ff[1]};
         forecast = hdr_ff[2][7:4];
         alt_value = {hdr_ff[4][3:0], hdr_ff[3]};
         second_forecast = hdr_ff[4][7:4];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {1'b0, second_forecast, alt_value, forecast, pres_value, humidity,
                        temp_value, sensor, hdr_ff[0], kind};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign status.short_item = len_ff <= wfr_pkg::SHORT_TRANSFER_MAX;
   assign status.big_count = count_ff >= wfr_pkg::COUNT_LIMIT;
   assign status.is_marker = (count_ff == wfr_pkg::MARKER_COUNT) &&
                             (pay_ff[0] == wfr_pkg::MARKER_BYTE);
   assign status.frame_empty = frame_len_ff == '0;
   assign status.marker_set = marker_ff;
   assign status.frame_short = frame_len_ff < LEN_W'(2);
   assign status.scan_done = (rd_ptr_ff == frame_len_ff) && !rd_vld_ff;
   assign status.sum_ok = sum_ff == chk_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

endmodule

### hdl/wfr_controller.sv
`timescale 1ns / 1ps

module wfr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  wfr_pkg::wfr_status_type status,
   output wfr_pkg::wfr_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLASSIFY,
      S_COPY,
      S_SCAN,
      S_CHECK,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            state_in = S_IDLE;
            if (status.short_item) begin
               state_in = S_IDLE;
            end else if (status.big_count) begin
               cmd.clear_frame = 1'b1;
            end else if (status.is_marker) begin
               if (status.frame_empty) begin
                  state_in = S_IDLE;
               end else if (!status.marker_set) begin
                  cmd.set_marker = 1'b1;
               end else if (status.frame_short) begin
                  cmd.clear_frame = 1'b1;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_done) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.sum_ok) begin
               state_in = S_EMIT;
            end else begin
               cmd.clear_frame = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               cmd.clear_frame = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/weather_frame_reassembler_top.sv
`timescale 1ns / 1ps

// Reassembles weather station frames from 8-byte interrupt transfers and emits one
// decoded record per good frame. An appending transfer stores one byte per cycle, up to 7.
// A frame-ending marker walks the frame store through its single read port, checks the
// checksum and, if it matches, waits for the previous record to be taken from the output
// register. Registers: 0 temperature type code (reset 66), 1 pressure type code
// (reset 70).

module weather_frame_reassembler_top #(
   parameter int FRAME_BYTES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // transfer_length[3:0], count_byte[11:4], payload_one..payload_seven[67:12], zero pad
   input  logic [wfr_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // record_kind[1:0], frame_type[9:2], sensor_number[13:10], temperature_value[22:14],
   // humidity_value[30:23], pressure_value[42:31], forecast_code[46:43],
   // second_pressure_value[58:47], second_forecast_code[62:59], zero pad
   output logic [wfr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wfr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wfr_pkg::CSR_DATA_W-1:0]       csr_data
);

   wfr_pkg::wfr_cmd_type    cmd;
   wfr_pkg::wfr_status_type status;
   logic [7:0]              payload [7];

   always_comb begin
      for (int k = 0; k < 7; k++) begin
         payload[k] = req_tdata[12 + 8 * k +: 8];
      end
   end

   wfr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wfr_datapath #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .transfer_length (req_tdata[3:0]),
      .count_byte      (req_tdata[11:4]),
      .payload         (payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

### hdl/wfr_checker.sv
`timescale 1ns / 1ps

module wfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   logic [1:0] kind;

   assign kind = rsp_tdata[1:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> kind != 2'd3)
      else $error("undefined record kind");

   a_temperature_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == wfr_pkg::KIND_TEMPERATURE |-> rsp_tdata[63:31] == '0)
      else $error("pressure fields set on a temperature record");

   a_pressure_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == wfr_pkg::KIND_PRESSURE |-> rsp_tdata[30:10] == '0)
      else $error("temperature fields set on a pressure record");

   a_other_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == wfr_pkg::KIND_OTHER |-> rsp_tdata[63:10] == '0)
      else $error("decoded fields set on an other-type record");

endmodule

bind weather_frame_reassembler_top wfr_checker u_wfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
